FILE: design/lscal_pkg.sv
`default_nettype none

package lscal_pkg;

	localparam int NCH   = 3;
	localparam int CH_W  = 12;
	localparam int MIN_W = 13;
	localparam int TOT_W = 16;
	localparam int CNT_W = 4;

	localparam logic [MIN_W-1:0] MIN_RESET = 13'd4096;

	typedef struct packed {
		logic            cliff_mode;
		logic            begin_req;
		logic            finish;
		logic [CH_W-1:0] sample_ch0;
		logic [CH_W-1:0] sample_ch1;
		logic [CH_W-1:0] sample_ch2;
	} sample_t;

	typedef struct packed {
		logic [CH_W-1:0] line_ref_ch0;
		logic [CH_W-1:0] line_ref_ch1;
		logic [CH_W-1:0] line_ref_ch2;
		logic [CH_W-1:0] cliff_ref_ch0;
		logic [CH_W-1:0] cliff_ref_ch1;
		logic [CH_W-1:0] cliff_ref_ch2;
		logic            cliff_done;
	} result_t;

	typedef struct packed {
		logic ld1;
		logic ld2;
		logic line_upd;
		logic line_clr;
		logic cliff_upd;
		logic cliff_clr;
		logic cliff_done;
	} lane_ctrl_t;

	typedef struct packed {
		logic [CH_W-1:0]  mid;
		logic [TOT_W-1:0] quot;
		logic [MIN_W-1:0] minv;
	} lane_res_t;

	typedef struct packed {
		logic cliff;
		logic finish;
		logic done;
	} item_t;

endpackage

`default_nettype wire

FILE: design/lscal_lane.sv
`default_nettype none

module lscal_lane #(
	parameter int unsigned SAMPLES = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lscal_pkg::lane_ctrl_t      ctrl,
	input  logic [lscal_pkg::CH_W-1:0] smp,
	output lscal_pkg::lane_res_t       res
);
	import lscal_pkg::*;

	localparam int SHIFT = TOT_W + $clog2(SAMPLES);
	localparam longint unsigned RECIP_L =
		((longint'(1) << SHIFT) + longint'(SAMPLES) - 1) / longint'(SAMPLES);
	localparam logic [SHIFT:0] RECIP = RECIP_L[SHIFT:0];
	localparam int PROD_W = TOT_W + SHIFT + 1;

	logic [MIN_W-1:0]  min_q, min_base, min_nx, smp_x;
	logic [CH_W-1:0]   max_q, max_base, max_nx;
	logic [TOT_W-1:0]  tot_q, tot_base, tot_sum;
	logic [MIN_W-1:0]  min_s1, min_s2;
	logic [CH_W-1:0]   max_s1, mid_s2;
	logic [TOT_W-1:0]  sum_s1, quot_s2;
	logic [CH_W+1:0]   mid_sum;
	logic [PROD_W-1:0] prod;

	assign smp_x    = {1'b0, smp};
	assign min_base = ctrl.line_clr ? MIN_RESET : min_q;
	assign max_base = ctrl.line_clr ? '0 : max_q;
	assign tot_base = ctrl.cliff_clr ? '0 : tot_q;
	assign tot_sum  = tot_base + {{(TOT_W-CH_W){1'b0}}, smp};

	always_comb begin
		min_nx = min_q;
		max_nx = max_q;
		if (ctrl.line_upd) begin
			min_nx = (smp_x < min_base) ? smp_x : min_base;
			max_nx = (smp > max_base) ? smp : max_base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MIN_RESET;
			max_q <= '0;
			tot_q <= '0;
		end else begin
			min_q <= min_nx;
			max_q <= max_nx;
			if (ctrl.cliff_upd) begin
				tot_q <= ctrl.cliff_done ? '0 : tot_sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld1) begin
			min_s1 <= min_nx;
			max_s1 <= max_nx;
			sum_s1 <= tot_sum;
		end
	end

	// average by reciprocal multiply, exact for every total
	assign mid_sum = {1'b0, min_s1} + {2'b00, max_s1};
	assign prod    = {{(SHIFT+1){1'b0}}, sum_s1} * {{TOT_W{1'b0}}, RECIP};

	always_ff @(posedge clk) begin
		if (ctrl.ld2) begin
			mid_s2  <= mid_sum[CH_W:1];
			quot_s2 <= prod[SHIFT +: TOT_W];
			min_s2  <= min_s1;
		end
	end

	assign res = '{mid: mid_s2, quot: quot_s2, minv: min_s2};

endmodule

`default_nettype wire

FILE: design/lscal_merge.sv
`default_nettype none

module lscal_merge (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  lscal_pkg::item_t     item,
	input  lscal_pkg::lane_res_t res [lscal_pkg::NCH],
	output lscal_pkg::result_t   word
);
	import lscal_pkg::*;

	logic [CH_W-1:0]  line_ref_q  [NCH];
	logic [CH_W-1:0]  cliff_ref_q [NCH];
	logic             done_q;
	logic [CH_W-1:0]  fin_blend   [NCH];
	logic [CH_W-1:0]  avg_blend   [NCH];
	logic [CH_W:0]    fin_sum     [NCH];
	logic [TOT_W:0]   avg_sum     [NCH];
	logic             all_cl_lt, all_av_lt;

	always_comb begin
		all_cl_lt = 1'b1;
		all_av_lt = 1'b1;
		for (int i = 0; i < NCH; i++) begin
			fin_sum[i]   = {1'b0, cliff_ref_q[i]} + {1'b0, res[i].mid};
			fin_blend[i] = fin_sum[i][CH_W:1];
			avg_sum[i]   = {1'b0, res[i].quot} + {{(TOT_W-MIN_W+1){1'b0}}, res[i].minv};
			avg_blend[i] = avg_sum[i][CH_W:1];
			if (!(cliff_ref_q[i] < res[i].mid)) begin
				all_cl_lt = 1'b0;
			end
			if (!(res[i].quot < {{(TOT_W-MIN_W){1'b0}}, res[i].minv})) begin
				all_av_lt = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCH; i++) begin
				line_ref_q[i]  <= '0;
				cliff_ref_q[i] <= '0;
			end
			done_q <= 1'b0;
		end else if (take) begin
			done_q <= item.cliff && item.done;
			for (int i = 0; i < NCH; i++) begin
				if (!item.cliff) begin
					line_ref_q[i] <= res[i].mid;
					if (item.finish && all_cl_lt) begin
						cliff_ref_q[i] <= fin_blend[i];
					end
				end else if (item.done) begin
					cliff_ref_q[i] <= all_av_lt ? avg_blend[i] : res[i].quot[CH_W-1:0];
				end
			end
		end
	end

	assign word = '{
		line_ref_ch0:  line_ref_q[0],
		line_ref_ch1:  line_ref_q[1],
		line_ref_ch2:  line_ref_q[2],
		cliff_ref_ch0: cliff_ref_q[0],
		cliff_ref_ch1: cliff_ref_q[1],
		cliff_ref_ch2: cliff_ref_q[2],
		cliff_done:    done_q
	};

endmodule

`default_nettype wire

FILE: design/line_sensor_reference_calibrator.sv
`default_nettype none

// Takes one sample word per clock while sample_stall is low and returns one
// result word for each through three register stages; sustained rate is one
// word per cycle while the output is not stalled. Three channel lanes update
// their extrema and cliff totals in the first stage, form the midpoint and the
// cliff average (a reciprocal multiply by SAMPLES) in the second, and a merge
// stage holding the line and cliff references applies the all-channel tests
// and blends in the third. The result register holds a stalled word while the
// stages behind it keep filling; sample_stall rises only once all three stages
// are occupied and the output is stalled.
module line_sensor_reference_calibrator #(
	parameter int unsigned SAMPLES = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_stall,
	input  lscal_pkg::sample_t  sample,
	output logic                result_valid,
	input  logic                result_stall,
	output lscal_pkg::result_t  result
);
	import lscal_pkg::*;

	localparam logic [CNT_W-1:0] SAMPLES_C = CNT_W'(SAMPLES);

	logic             valid_s1, valid_s2, valid_s3;
	logic             ld1, ld2, ld3, acc;
	logic [CNT_W-1:0] count_q, count_base, count_inc;
	logic             run_done;
	item_t            item_nx, item_s1, item_s2;
	lane_ctrl_t       ctrl;
	lane_res_t        res [NCH];
	logic [CH_W-1:0]  smp [NCH];

	assign ld3          = !valid_s3 || !result_stall;
	assign ld2          = !valid_s2 || ld3;
	assign ld1          = !valid_s1 || ld2;
	assign sample_stall = !ld1;
	assign acc          = sample_valid && ld1;

	assign count_base = sample.begin_req ? '0 : count_q;
	assign count_inc  = count_base + 1'b1;
	assign run_done   = sample.cliff_mode && (count_inc >= SAMPLES_C);

	assign ctrl = '{
		ld1:        ld1,
		ld2:        ld2,
		line_upd:   acc && !sample.cliff_mode,
		line_clr:   sample.begin_req,
		cliff_upd:  acc && sample.cliff_mode,
		cliff_clr:  sample.begin_req,
		cliff_done: run_done
	};

	assign item_nx = '{cliff: sample.cliff_mode, finish: sample.finish, done: run_done};

	assign smp[0] = sample.sample_ch0;
	assign smp[1] = sample.sample_ch1;
	assign smp[2] = sample.sample_ch2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (acc && sample.cliff_mode) begin
				count_q <= run_done ? '0 : count_inc;
			end
			if (ld1) begin
				valid_s1 <= sample_valid;
			end
			if (ld2) begin
				valid_s2 <= valid_s1;
			end
			if (ld3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			item_s1 <= item_nx;
		end
		if (ld2) begin
			item_s2 <= item_s1;
		end
	end

	for (genvar g = 0; g < NCH; g++) begin : g_lane
		lscal_lane #(
			.SAMPLES (SAMPLES)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.smp    (smp[g]),
			.res    (res[g])
		);
	end

	lscal_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (ld3 && valid_s2),
		.item   (item_s2),
		.res    (res),
		.word   (result)
	);

	assign result_valid = valid_s3;

endmodule

`default_nettype wire

FILE: design/lscal_chk.sv
`default_nettype none

module lscal_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               sample_valid,
	input logic               sample_stall,
	input lscal_pkg::sample_t sample,
	input logic               result_valid,
	input logic               result_stall,
	input lscal_pkg::result_t result
);
	import lscal_pkg::*;

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result word changed");

	// free-running output presents the word of each accepted sample
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall) ##1 !result_stall ##1 !result_stall |=> result_valid)
		else $error("result word missing after accepted sample");

	a_empty_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !result_valid)
		else $error("result valid right after reset");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> result_valid && result_stall)
		else $error("input stalled while output free");

endmodule

bind line_sensor_reference_calibrator lscal_chk u_lscal_chk (.*);

`default_nettype wire

FILE: verif/line_sensor_reference_calibrator_checker.sv
`default_nettype none

module line_sensor_reference_calibrator_checker #(
	parameter int unsigned SAMPLES = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	input  logic               sample_stall,
	input  lscal_pkg::sample_t sample,
	input  logic               result_valid,
	input  logic               result_stall,
	input  lscal_pkg::result_t result,
	output int                 errors,
	output int                 outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import lscal_pkg::*;

	logic [MIN_W-1:0] ch_min [NCH];
	logic [CH_W-1:0]  ch_max [NCH];
	logic [CH_W-1:0]  line_ref [NCH];
	logic [CH_W-1:0]  cliff_ref [NCH];
	logic [TOT_W-1:0] cliff_sum [NCH];
	logic [CNT_W-1:0] cliff_cnt;

	result_t predicted_refs [$];
	result_t next_refs;
	result_t want;
	logic [CH_W-1:0] want_f [7];
	logic [CH_W-1:0] got_f [7];
	string field_name [7] = '{"line_ref_ch0", "line_ref_ch1", "line_ref_ch2",
		"cliff_ref_ch0", "cliff_ref_ch1", "cliff_ref_ch2", "cliff_done"};

	task automatic note_mismatch(input string msg);
		errors++;
		if (errors <= 10) begin
			$display("%0t mismatch: %s", $realtime, msg);
		end
	endtask

	// update the calibration state with one accepted word, return the refs it leaves
	task automatic calibrate(input sample_t w, output result_t r);
		logic [CH_W-1:0]  s [NCH];
		logic [TOT_W-1:0] avg [NCH];
		logic [MIN_W:0]   sum;
		bit               all_below;
		bit               done;
		s[0] = w.sample_ch0;
		s[1] = w.sample_ch1;
		s[2] = w.sample_ch2;
		done = 1'b0;
		if (!w.cliff_mode) begin
			if (w.begin_req) begin
				for (int i = 0; i < NCH; i++) begin
					ch_min[i] = MIN_RESET;
					ch_max[i] = '0;
				end
			end
			for (int i = 0; i < NCH; i++) begin
				if ({1'b0, s[i]} < ch_min[i]) ch_min[i] = {1'b0, s[i]};
				if (s[i] > ch_max[i]) ch_max[i] = s[i];
				sum = {1'b0, ch_min[i]} + {2'b00, ch_max[i]};
				line_ref[i] = sum[CH_W:1];
			end
			if (w.finish) begin
				all_below = 1'b1;
				for (int i = 0; i < NCH; i++) begin
					if (!(cliff_ref[i] < line_ref[i])) all_below = 1'b0;
				end
				if (all_below) begin
					for (int i = 0; i < NCH; i++) begin
						sum = {2'b00, cliff_ref[i]} + {2'b00, line_ref[i]};
						cliff_ref[i] = sum[CH_W:1];
					end
				end
			end
		end else begin
			if (w.begin_req) begin
				for (int i = 0; i < NCH; i++) cliff_sum[i] = '0;
				cliff_cnt = '0;
			end
			for (int i = 0; i < NCH; i++) cliff_sum[i] = cliff_sum[i] + TOT_W'(s[i]);
			cliff_cnt = cliff_cnt + 1'b1;
			if (cliff_cnt >= SAMPLES) begin
				all_below = 1'b1;
				for (int i = 0; i < NCH; i++) begin
					avg[i] = TOT_W'(cliff_sum[i] / SAMPLES);
					if (!(avg[i] < TOT_W'(ch_min[i]))) all_below = 1'b0;
				end
				for (int i = 0; i < NCH; i++) begin
					if (all_below) avg[i] = (avg[i] + TOT_W'(ch_min[i])) >> 1;
					cliff_ref[i] = avg[i][CH_W-1:0];
					cliff_sum[i] = '0;
				end
				cliff_cnt = '0;
				done = 1'b1;
			end
		end
		r.line_ref_ch0  = line_ref[0];
		r.line_ref_ch1  = line_ref[1];
		r.line_ref_ch2  = line_ref[2];
		r.cliff_ref_ch0 = cliff_ref[0];
		r.cliff_ref_ch1 = cliff_ref[1];
		r.cliff_ref_ch2 = cliff_ref[2];
		r.cliff_done    = done;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCH; i++) begin
				ch_min[i]    = MIN_RESET;
				ch_max[i]    = '0;
				line_ref[i]  = '0;
				cliff_ref[i] = '0;
				cliff_sum[i] = '0;
			end
			cliff_cnt = '0;
			predicted_refs.delete();
		end else begin
			if (sample_valid && !sample_stall) begin
				calibrate(sample, next_refs);
				predicted_refs.push_back(next_refs);
			end
			if (result_valid && !result_stall) begin
				if (predicted_refs.size() == 0) begin
					note_mismatch($sformatf("unexpected word %h", result));
				end else begin
					want = predicted_refs.pop_front();
					want_f = '{want.line_ref_ch0, want.line_ref_ch1, want.line_ref_ch2,
						want.cliff_ref_ch0, want.cliff_ref_ch1, want.cliff_ref_ch2,
						CH_W'(want.cliff_done)};
					got_f = '{result.line_ref_ch0, result.line_ref_ch1, result.line_ref_ch2,
						result.cliff_ref_ch0, result.cliff_ref_ch1, result.cliff_ref_ch2,
						CH_W'(result.cliff_done)};
					for (int i = 0; i < 7; i++) begin
						if (got_f[i] !== want_f[i]) begin
							note_mismatch($sformatf("%s expected %0d got %0d",
								field_name[i], want_f[i], got_f[i]));
						end
					end
				end
			end
		end
		outstanding = predicted_refs.size();
	end

endmodule

`default_nettype wire

FILE: verif/line_sensor_reference_calibrator_test.sv
`default_nettype none

module line_sensor_reference_calibrator_test;
	timeunit 1ns;
	timeprecision 1ps;
	import lscal_pkg::*;

	localparam int unsigned SAMPLES = 10;
	localparam int WORD_COUNT = 1925;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    sample_valid = 1'b0;
	sample_t sample = '0;
	logic    result_stall = 1'b0;
	logic    sample_stall;
	logic    result_valid;
	result_t result;
	int      errors;
	int      outstanding;
	int      sent = 0;
	int      burst_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	line_sensor_reference_calibrator #(
		.SAMPLES(SAMPLES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	line_sensor_reference_calibrator_checker #(
		.SAMPLES(SAMPLES)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.errors(errors),
		.outstanding(outstanding)
	);

	// mostly short pauses, a few long ones
	function automatic int pause_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 80) return $urandom_range(1, 3);
		if (roll < 95) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [CH_W-1:0] pick(input int lo, input int hi);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 4) return '0;
		if (roll < 8) return '1;
		return CH_W'($urandom_range(lo, hi));
	endfunction

	function automatic sample_t make_word(input bit cliff, input bit start, input bit fin,
		input logic [CH_W-1:0] a, input logic [CH_W-1:0] b, input logic [CH_W-1:0] c);
		sample_t w;
		w.cliff_mode = cliff;
		w.begin_req  = start;
		w.finish     = fin;
		w.sample_ch0 = a;
		w.sample_ch1 = b;
		w.sample_ch2 = c;
		return w;
	endfunction

	task automatic send_word(input sample_t w);
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end else if ($urandom_range(0, 99) < 3) begin
			burst_left = $urandom_range(20, 80);
			gap = 0;
		end else begin
			gap = ($urandom_range(0, 99) < 50) ? 0 : pause_len();
		end
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= w;
		do @(negedge clk); while (sample_stall);
		@(posedge clk);
		sent++;
	endtask

	initial begin
		int roll;
		int n;
		int lo;
		int hi;
		bit start;
		bit fin;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// line word straight after reset, then finish with an empty cliff ref
		send_word(make_word(1'b0, 1'b0, 1'b0, 12'd0, 12'd4095, 12'd2048));
		send_word(make_word(1'b0, 1'b0, 1'b1, 12'd4095, 12'd0, 12'd1));
		send_word(make_word(1'b0, 1'b1, 1'b0, 12'd4095, 12'd4095, 12'd4095));
		send_word(make_word(1'b0, 1'b0, 1'b0, 12'd3000, 12'd3500, 12'd4000));
		// cliff run below the minima, finish flag ignored here
		send_word(make_word(1'b1, 1'b1, 1'b1, 12'd0, 12'd0, 12'd0));
		for (int k = 1; k <= 9; k++) begin
			send_word(make_word(1'b1, 1'b0, 1'(k % 2), CH_W'(100 * k), CH_W'(200 * k),
				CH_W'(300 * k)));
		end
		send_word(make_word(1'b0, 1'b0, 1'b1, 12'd3800, 12'd3900, 12'd4000));
		// cliff run at full scale, no blend
		send_word(make_word(1'b1, 1'b1, 1'b0, 12'd4095, 12'd4095, 12'd4095));
		repeat (9) send_word(make_word(1'b1, 1'b0, 1'b0, 12'd4095, 12'd4095, 12'd4095));

		while (sent < WORD_COUNT) begin
			roll = $urandom_range(0, 99);
			if (roll < 40) begin
				n = $urandom_range(1, 12);
				lo = $urandom_range(0, 4095);
				hi = $urandom_range(lo, 4095);
				for (int j = 0; j < n; j++) begin
					start = (j == 0) && ($urandom_range(0, 9) < 8);
					fin = (j == n - 1) && ($urandom_range(0, 9) < 7);
					send_word(make_word(1'b0, start, fin, pick(lo, hi), pick(lo, hi),
						pick(lo, hi)));
				end
			end else if (roll < 82) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, SAMPLES) : SAMPLES;
				lo = $urandom_range(0, 2500);
				hi = $urandom_range(lo, 4095);
				for (int j = 0; j < n; j++) begin
					start = (j == 0) ? ($urandom_range(0, 9) < 8) : ($urandom_range(0, 99) < 2);
					fin = ($urandom_range(0, 3) == 0);
					send_word(make_word(1'b1, start, fin, pick(lo, hi), pick(lo, hi),
						pick(lo, hi)));
				end
			end else begin
				send_word(make_word(1'($urandom), 1'($urandom), 1'($urandom),
					CH_W'($urandom), CH_W'($urandom), CH_W'($urandom)));
			end
		end
		sample_valid <= 1'b0;

		do @(negedge clk); while (outstanding != 0);
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("PASS line_sensor_reference_calibrator");
		end else begin
			$display("FAIL line_sensor_reference_calibrator");
		end
		$finish;
	end

	initial begin
		wait (arst_n);
		forever begin
			repeat (($urandom_range(0, 99) < 5) ? $urandom_range(100, 300) : $urandom_range(1, 20))
				@(posedge clk);
			result_stall <= 1'b1;
			repeat (pause_len()) @(posedge clk);
			result_stall <= 1'b0;
		end
	end

	initial begin
		#10_000_000;
		$display("FAIL line_sensor_reference_calibrator");
		$finish;
	end

endmodule

`default_nettype wire
